>>> rtl/core/stbs_pkg.sv
// shared types and constants for the sorted key table with binary search
package stbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int PTR_W       = ADDR_W + 2;

  // result field widths
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int PROBE_W  = 4;
  localparam int PROBE_MAX = ADDR_W + 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNSORTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic take_simple;   // item handled without probing: clear, append, error or unused code
    logic start_search;  // load search range and issue first probe read
    logic probe;         // compare probe data and step the range
    logic load_search;   // move the search result into the output register
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic table_empty;
    logic table_unsorted;
    logic probe_done;    // the current probe ends the search
  } stat_t;

endpackage

>>> rtl/core/stbs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/stbs_ctrl.sv
// controller state machine: sequences items, probes and the output register
module stbs_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [stbs_pkg::CMD_W-1:0]   in_command,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  stbs_pkg::stat_t              stat,
  output stbs_pkg::ctrl_t              ctl
);

  import stbs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_HOLD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_xfer;
  logic   search_go;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_xfer    = in_tvalid && in_tready;
  assign search_go  = (in_command == CMD_SEARCH) && !stat.table_empty &&
                      !stat.table_unsorted;
  assign out_tvalid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (search_go) begin
            ctl.start_search = 1'b1;
            state_nxt        = S_PROBE;
          end else begin
            ctl.take_simple = 1'b1;
          end
        end
      end
      S_PROBE: begin
        ctl.probe = 1'b1;
        if (stat.probe_done) begin
          if (out_free) begin
            ctl.load_search = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          ctl.load_search = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.take_simple || ctl.load_search) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a held search result only waits behind an occupied output register
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> out_valid_r)
    else $error("hold state with empty output register");

  // a search result load always leaves a transfer pending
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_search |=> out_valid_r)
    else $error("search result load lost");

  // probing continues until the datapath reports the end
  a_probe_stay: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) && !stat.probe_done |=> state_r == S_PROBE)
    else $error("search left before its last probe");

endmodule

>>> rtl/core/stbs_dp.sv
// datapath: key ram, table bookkeeping, search range and output payload
module stbs_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [stbs_pkg::CMD_W-1:0]       in_command,
  input  logic [stbs_pkg::KEY_BITS-1:0]    in_key,
  input  stbs_pkg::ctrl_t                  ctl,
  output stbs_pkg::stat_t                  stat,
  output logic [stbs_pkg::STATUS_W-1:0]    out_status,
  output logic [stbs_pkg::ADDR_W-1:0]      out_index,
  output logic [stbs_pkg::PROBE_W-1:0]     out_probes,
  output logic [stbs_pkg::CNT_W-1:0]       out_total
);

  import stbs_pkg::*;

  // table state
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       unsorted_r, unsorted_nxt;
  logic signed [KEY_BITS-1:0] last_key_r, last_key_nxt;

  // search state
  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic signed [PTR_W-1:0]    lo_r, lo_nxt;
  logic signed [PTR_W-1:0]    hi_r, hi_nxt;
  logic [ADDR_W-1:0]          mid_r, mid_nxt;
  logic [PROBE_W-1:0]         probe_r, probe_nxt;
  logic [STATUS_W-1:0]        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]          res_index_r, res_index_nxt;

  // output payload
  logic [STATUS_W-1:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]          out_index_r, out_index_nxt;
  logic [PROBE_W-1:0]         out_probes_r, out_probes_nxt;
  logic [CNT_W-1:0]           out_total_r, out_total_nxt;

  // ram ports
  logic                       wr_en;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [KEY_BITS-1:0]        rd_data;

  // probe evaluation
  logic signed [KEY_BITS-1:0] probe_key;
  logic                       hit;
  logic                       below;
  logic signed [PTR_W-1:0]    mid_ext;
  logic signed [PTR_W-1:0]    lo_c;
  logic signed [PTR_W-1:0]    hi_c;
  logic signed [PTR_W-1:0]    sum_c;
  logic                       end_c;
  logic [ADDR_W-1:0]          next_mid;
  logic [PROBE_W-1:0]         probe_inc;
  logic [STATUS_W-1:0]        srch_status;
  logic [ADDR_W-1:0]          srch_index;

  // search start values
  logic [CNT_W-1:0]           cnt_m1;
  logic [ADDR_W-1:0]          mid0;

  // simple command results
  logic                       full;
  logic                       append_ok;
  logic [STATUS_W-1:0]        simple_status;

  stbs_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[ADDR_W-1:0]),
    .wr_data(in_key),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // compare the probed entry and narrow the range
  assign probe_key   = signed'(rd_data);
  assign hit         = (probe_key == key_r);
  assign below       = (probe_key < key_r);
  assign mid_ext     = signed'({{(PTR_W-ADDR_W){1'b0}}, mid_r});
  assign lo_c        = below ? (mid_ext + PTR_W'(1)) : lo_r;
  assign hi_c        = below ? hi_r : (mid_ext - PTR_W'(1));
  assign sum_c       = lo_c + hi_c;
  assign next_mid    = sum_c[ADDR_W:1];
  assign end_c       = hit || (lo_c > hi_c);
  assign probe_inc   = probe_r + PROBE_W'(1);
  assign srch_status = hit ? ST_OK : ST_NOT_FOUND;
  assign srch_index  = hit ? mid_r : '0;

  // first probe sits in the middle of the filled entries
  assign cnt_m1 = count_r - CNT_W'(1);
  assign mid0   = cnt_m1[ADDR_W:1];

  assign rd_en   = ctl.start_search || (ctl.probe && !end_c);
  assign rd_addr = ctl.start_search ? mid0 : next_mid;

  // commands that need no probing
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));
  assign append_ok = ctl.take_simple && (in_command == CMD_APPEND) && !full;
  assign wr_en     = append_ok;

  always_comb begin
    case (in_command)
      CMD_APPEND: simple_status = full ? ST_FULL : ST_OK;
      CMD_SEARCH: simple_status = (count_r == '0) ? ST_EMPTY : ST_UNSORTED;
      default:    simple_status = ST_OK;
    endcase
  end

  // table bookkeeping
  always_comb begin
    count_nxt    = count_r;
    unsorted_nxt = unsorted_r;
    last_key_nxt = last_key_r;
    if (ctl.take_simple && (in_command == CMD_CLEAR)) begin
      count_nxt    = '0;
      unsorted_nxt = 1'b0;
    end
    if (append_ok) begin
      count_nxt    = count_r + CNT_W'(1);
      last_key_nxt = signed'(in_key);
      if ((count_r != '0) && (signed'(in_key) < last_key_r)) begin
        unsorted_nxt = 1'b1;
      end
    end
  end

  // search range and result
  always_comb begin
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    probe_nxt      = probe_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    if (ctl.start_search) begin
      key_nxt   = signed'(in_key);
      lo_nxt    = '0;
      hi_nxt    = signed'({1'b0, cnt_m1});
      mid_nxt   = mid0;
      probe_nxt = '0;
    end
    if (ctl.probe) begin
      lo_nxt         = lo_c;
      hi_nxt         = hi_c;
      mid_nxt        = next_mid;
      probe_nxt      = probe_inc;
      res_status_nxt = srch_status;
      res_index_nxt  = srch_index;
    end
  end

  // output payload
  always_comb begin
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_probes_nxt = out_probes_r;
    out_total_nxt  = out_total_r;
    if (ctl.take_simple) begin
      out_status_nxt = simple_status;
      out_index_nxt  = '0;
      out_probes_nxt = '0;
      out_total_nxt  = count_nxt;
    end
    if (ctl.load_search) begin
      out_status_nxt = ctl.probe ? srch_status : res_status_r;
      out_index_nxt  = ctl.probe ? srch_index  : res_index_r;
      out_probes_nxt = ctl.probe ? probe_inc   : probe_r;
      out_total_nxt  = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      unsorted_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      unsorted_r <= unsorted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_key_r   <= last_key_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    probe_r      <= probe_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_probes_r <= out_probes_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign stat.table_empty    = (count_r == '0);
  assign stat.table_unsorted = unsorted_r;
  assign stat.probe_done     = end_c;

  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_probes = out_probes_r;
  assign out_total  = out_total_r;

  // the range being probed is never empty
  a_range_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.probe |-> (lo_r <= hi_r) && (lo_r >= 0))
    else $error("probe with empty search range");

  // a search never runs past the probe bound of the table depth
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.probe |-> probe_r < PROBE_W'(PROBE_MAX))
    else $error("search exceeded probe bound");

  // searches start only on a non-empty, sorted table
  a_start_filled: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start_search |-> (count_r != '0) && !unsorted_r)
    else $error("search started on empty or unsorted table");

endmodule

>>> rtl/core/sorted_table_binary_search.sv
// top level of the sorted key table with binary search
//
//  channel  direction  tdata (low bit up)                          tuser
//  in_      slave      key_value[31:0]                             command[1:0]
//  out_     master     found_index[7:0] probe_count[11:8]          status[2:0]
//                      entry_total[20:12] zero[23:21]
//
// clear, append and searches refused as empty or unsorted need no ram probe.
// a search issues its first ram read, then makes its probes one after another
// (1 to 9 for 256 entries), as the single ram read port and the compare that
// chooses the next midpoint allow only one probe at a time.
// synchronous active-low reset empties the table; the key ram needs no clearing.
// a new item is taken in the cycle the previous result transfers out.
module sorted_table_binary_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key_value[31:0]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // found_index[7:0], probe_count[11:8], entry_total[20:12]
  output logic [2:0]  out_tuser   // status[2:0]
);

  import stbs_pkg::*;

  ctrl_t               ctl;
  stat_t               stat;
  logic [ADDR_W-1:0]   out_index;
  logic [PROBE_W-1:0]  out_probes;
  logic [CNT_W-1:0]    out_total;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_command(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  stbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_command(in_tuser),
    .in_key    (in_tdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_status(out_tuser),
    .out_index (out_index),
    .out_probes(out_probes),
    .out_total (out_total)
  );

  // pack the result payload
  assign out_tdata = {3'b000, out_total, out_probes, out_index};

endmodule
